// ===== rtl/tti_pkg.sv =====
// Package for the tensor transpose index remapper.
// Holds the shape limits, register indexes, shared struct types and helpers.
// Used by every module in the rtl folder.
`timescale 1ns / 1ps
`default_nettype none

package tti_pkg;

   // Shape and datapath limits.
   localparam int MAX_DIMS   = 4;
   localparam int ADDR_BITS  = 24;
   localparam int DIM_BITS   = 16;
   localparam int ELEM_W     = 32;
   localparam int RANK_W     = 3;
   localparam int AXIS_W     = 3;
   localparam int AXN_W      = RANK_W + 1;
   localparam int IDX_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Running product width: one above the address range so overflow is visible.
   localparam int ACC_W  = ADDR_BITS + 1;
   localparam int PROD_W = ACC_W + DIM_BITS;

   localparam logic [ACC_W-1:0] ADDR_LIMIT = ACC_W'(1) << ADDR_BITS;
   localparam logic [ACC_W-1:0] ACC_SAT    = ADDR_LIMIT + ACC_W'(1);

   // Output stream data: address and element packed, padded to whole bytes.
   localparam int RSP_DATA_W  = ADDR_BITS + ELEM_W;
   localparam int RSP_TDATA_W = ((RSP_DATA_W + 7) / 8) * 8;

   // Register reset values.
   localparam logic [RANK_W-1:0]   RANK_RESET        = RANK_W'(2);
   localparam logic [DIM_BITS-1:0] SIZE_RESET        = DIM_BITS'(1);
   localparam logic [AXIS_W-1:0]   SWAP_FIRST_RESET  = AXIS_W'(0);
   localparam logic [AXIS_W-1:0]   SWAP_SECOND_RESET = AXIS_W'(1);

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANK        = 3'd0,
      CSR_SIZE_DIM0   = 3'd1,
      CSR_SIZE_DIM1   = 3'd2,
      CSR_SIZE_DIM2   = 3'd3,
      CSR_SIZE_DIM3   = 3'd4,
      CSR_SWAP_FIRST  = 3'd5,
      CSR_SWAP_SECOND = 3'd6
   } csr_index_type;

   // Stride sequencer states.
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_STRIDE,
      SEQ_DELTA
   } seq_state_type;

   typedef logic [MAX_DIMS-1:0][DIM_BITS-1:0]  dim_vec_type;
   typedef logic [MAX_DIMS-1:0][ADDR_BITS-1:0] addr_vec_type;

   // Shape state handed from the configuration block to the index walker.
   typedef struct packed {
      logic              busy;
      logic              restart;
      logic              fault;
      logic [RANK_W-1:0] rank;
      dim_vec_type       size;
      addr_vec_type      delta;
   } cfg_state_type;

   // One result transaction.
   typedef struct packed {
      logic                 fault;
      logic                 is_last;
      logic [ELEM_W-1:0]    elem_out;
      logic [ADDR_BITS-1:0] dest_addr;
   } rsp_type;

   // Position of input axis i in the output shape: the two swapped axes trade places.
   function automatic logic [IDX_W-1:0] swap_pos(
      input logic [IDX_W-1:0] i,
      input logic [IDX_W-1:0] a,
      input logic [IDX_W-1:0] b
   );
      logic [IDX_W-1:0] p;
      p = i;
      if (i == a) begin
         p = b;
      end else if (i == b) begin
         p = a;
      end
      return p;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tti_skid.sv =====
// Two-entry output stage for result transactions: output register plus skid register.
// Depends on tti_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module tti_skid
   import tti_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire rsp_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    push, pop;

   // Ready depends only on registered state, so the two sides stay decoupled.
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   assign push = in_valid && in_ready;
   assign pop  = main_valid_ff && out_ready;

   // Next state of the two entries.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // The skid entry is only ever filled behind a full output register.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> main_valid_ff)
      else $error("skid entry holds data while output register is empty");

   // A held skid entry moves forward as soon as the output register drains.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> main_valid_ff && !skid_valid_ff && main_ff == $past(skid_ff))
      else $error("skid entry was not forwarded on drain");

endmodule

`default_nettype wire

// ===== rtl/tti_cfg.sv =====
// Configuration registers, shape checks and the stride sequencer.
// Computes the output strides and per-axis address steps with a shared datapath of two multipliers.
// Depends on tti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tti_cfg
   import tti_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wen,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_state_type              cfg
);

   logic [RANK_W-1:0] rank_ff;
   dim_vec_type       size_ff;
   logic [AXIS_W-1:0] swap_first_ff;
   logic [AXIS_W-1:0] swap_second_ff;

   seq_state_type        state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [ADDR_BITS-1:0] sum_ff, sum_in;
   addr_vec_type         ostr_ff, ostr_in;
   addr_vec_type         delta_ff, delta_in;

   logic                    restart;
   logic signed [AXN_W-1:0] rank_s, a_raw, b_raw, a_norm, b_norm;
   logic                    rank_bad, axis_bad, size_zero, too_large;
   logic [IDX_W-1:0]        axis_a, axis_b, pos_idx, size_addr;
   logic [DIM_BITS-1:0]     size_sel;
   logic [ADDR_BITS-1:0]    str_sel, size_m1, term;
   logic [PROD_W-1:0]       prod;
   logic                    used;

   // Any write to a known register starts a new tensor.
   assign restart = csr_wen && (csr_index <= CSR_IDX_W'(CSR_SWAP_SECOND));

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff        <= RANK_RESET;
         size_ff        <= {MAX_DIMS{SIZE_RESET}};
         swap_first_ff  <= SWAP_FIRST_RESET;
         swap_second_ff <= SWAP_SECOND_RESET;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_RANK:        rank_ff        <= csr_wdata[RANK_W-1:0];
            CSR_SIZE_DIM0:   size_ff[0]     <= csr_wdata[DIM_BITS-1:0];
            CSR_SIZE_DIM1:   size_ff[1]     <= csr_wdata[DIM_BITS-1:0];
            CSR_SIZE_DIM2:   size_ff[2]     <= csr_wdata[DIM_BITS-1:0];
            CSR_SIZE_DIM3:   size_ff[3]     <= csr_wdata[DIM_BITS-1:0];
            CSR_SWAP_FIRST:  swap_first_ff  <= csr_wdata[AXIS_W-1:0];
            CSR_SWAP_SECOND: swap_second_ff <= csr_wdata[AXIS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Axis normalization: a negative axis counts from the end.
   always_comb begin
      rank_s   = signed'(AXN_W'(rank_ff));
      a_raw    = AXN_W'(signed'(swap_first_ff));
      b_raw    = AXN_W'(signed'(swap_second_ff));
      a_norm   = (a_raw < 0) ? a_raw + rank_s : a_raw;
      b_norm   = (b_raw < 0) ? b_raw + rank_s : b_raw;
      axis_bad = (a_norm < 0) || (a_norm >= rank_s) || (b_norm < 0) || (b_norm >= rank_s);
      axis_a   = a_norm[IDX_W-1:0];
      axis_b   = b_norm[IDX_W-1:0];
   end

   // Shape checks; the element count check reads the finished running product.
   always_comb begin
      rank_bad  = (rank_ff == '0) || (rank_ff > RANK_W'(MAX_DIMS));
      size_zero = 1'b0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         if ((RANK_W'(d) < rank_ff) && (size_ff[d] == '0)) begin
            size_zero = 1'b1;
         end
      end
      too_large = acc_ff > ADDR_LIMIT;
   end

   // Shared datapath: one multiply per sequencer step.
   always_comb begin
      used      = RANK_W'(idx_ff) < rank_ff;
      pos_idx   = swap_pos(idx_ff, axis_a, axis_b);
      size_addr = (state_ff == SEQ_STRIDE) ? pos_idx : idx_ff;
      size_sel  = size_ff[size_addr];
      str_sel   = ostr_ff[pos_idx];
      prod      = PROD_W'(acc_ff) * PROD_W'(size_sel);
      size_m1   = ADDR_BITS'(DIM_BITS'(size_sel - 1'b1));
      term      = size_m1 * str_sel;
   end

   // Sequencer. The stride pass walks the axes innermost first and keeps the running
   // product; the step pass folds the wrap of all inner axes into one address step each.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      acc_in   = acc_ff;
      sum_in   = sum_ff;
      ostr_in  = ostr_ff;
      delta_in = delta_ff;
      if (restart) begin
         state_in = SEQ_STRIDE;
         idx_in   = IDX_W'(MAX_DIMS - 1);
         acc_in   = ACC_W'(1);
      end else begin
         unique case (state_ff)
            SEQ_IDLE: begin
            end
            SEQ_STRIDE: begin
               if (used) begin
                  ostr_in[idx_ff] = acc_ff[ADDR_BITS-1:0];
                  acc_in = (prod > PROD_W'(ADDR_LIMIT)) ? ACC_SAT : prod[ACC_W-1:0];
               end
               if (idx_ff == '0) begin
                  state_in = SEQ_DELTA;
                  idx_in   = IDX_W'(MAX_DIMS - 1);
                  sum_in   = '0;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
            SEQ_DELTA: begin
               if (used) begin
                  delta_in[idx_ff] = str_sel - sum_ff;
                  sum_in = sum_ff + term;
               end
               if (idx_ff == '0) begin
                  state_in = SEQ_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
            default: begin
               state_in = SEQ_IDLE;
            end
         endcase
      end
   end

   // Reset runs the sequencer once so the reset shape is ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_STRIDE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= IDX_W'(MAX_DIMS - 1);
         acc_ff <= ACC_W'(1);
         sum_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         acc_ff <= acc_in;
         sum_ff <= sum_in;
      end
   end

   // Strides and steps of unused axes stay at a known value.
   always_ff @(posedge clock) begin
      if (reset) begin
         ostr_ff  <= '0;
         delta_ff <= '0;
      end else begin
         ostr_ff  <= ostr_in;
         delta_ff <= delta_in;
      end
   end

   assign cfg.busy    = (state_ff != SEQ_IDLE);
   assign cfg.restart = restart;
   assign cfg.fault   = rank_bad || axis_bad || size_zero || too_large;
   assign cfg.rank    = rank_ff;
   assign cfg.size    = size_ff;
   assign cfg.delta   = delta_ff;

   // A register write always restarts the stride pass.
   assert property (@(posedge clock) disable iff (reset) restart |=> state_ff == SEQ_STRIDE)
      else $error("register write did not restart the stride pass");

   // Address steps hold still once the sequencer is done.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == SEQ_IDLE && !restart |=> $stable(delta_ff))
      else $error("address steps changed while idle");

endmodule

`default_nettype wire

// ===== rtl/tti_walk.sv =====
// Index walker: the per-axis odometer and the running output address.
// Builds one result per accepted transaction. Depends on tti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tti_walk
   import tti_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_state_type     cfg,
   input  wire logic              accept,
   input  wire logic [ELEM_W-1:0] elem_bits,
   output rsp_type                rsp
);

   dim_vec_type          digit_ff, digit_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [ADDR_BITS-1:0] step;
   logic                 last;
   logic                 odo_ok;

   // Odometer advance, innermost axis first. The axis that increments picks its step;
   // when every used axis wraps, the element is the last one and the address restarts.
   always_comb begin
      logic carry;
      logic in_use;
      logic maxed;
      carry    = 1'b1;
      step     = '0;
      digit_in = digit_ff;
      odo_ok   = 1'b1;
      for (int d = MAX_DIMS - 1; d >= 0; d--) begin
         in_use = RANK_W'(d) < cfg.rank;
         maxed  = digit_ff[d] == DIM_BITS'(cfg.size[d] - 1'b1);
         if (in_use && carry) begin
            if (maxed) begin
               digit_in[d] = '0;
            end else begin
               digit_in[d] = DIM_BITS'(digit_ff[d] + 1'b1);
               step        = cfg.delta[d];
            end
         end
         if (in_use) begin
            odo_ok = odo_ok && (digit_ff[d] < cfg.size[d]);
         end else begin
            odo_ok = odo_ok && (digit_ff[d] == '0);
         end
         carry = carry && (!in_use || maxed);
      end
      last    = carry;
      addr_in = last ? '0 : addr_ff + step;
   end

   // A faulted shape leaves the odometer where it is.
   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         digit_ff <= '0;
         addr_ff  <= '0;
      end else if (accept && !cfg.fault) begin
         digit_ff <= digit_in;
         addr_ff  <= addr_in;
      end
   end

   assign rsp.fault     = cfg.fault;
   assign rsp.is_last   = !cfg.fault && last;
   assign rsp.elem_out  = elem_bits;
   assign rsp.dest_addr = cfg.fault ? '0 : addr_ff;

   // Every digit stays inside its axis extent, and unused axes stay at zero.
   assert property (@(posedge clock) disable iff (reset) !cfg.busy && !cfg.fault |-> odo_ok)
      else $error("odometer digit outside its axis extent");

   // After the last element the walk starts again from the origin.
   assert property (@(posedge clock) disable iff (reset)
      accept && rsp.is_last && !cfg.restart |=> addr_ff == '0 && digit_ff == '0)
      else $error("walk did not return to origin after last element");

endmodule

`default_nettype wire

// ===== rtl/tensor_transpose_index_remap.sv =====
// Top level of the two-axis tensor transpose index remapper.
// Instantiates tti_cfg, tti_walk and tti_skid; depends on tti_pkg.
//
// Usage:
// Elements of the input tensor arrive on the req_ channel in row-major order, one
// 32-bit word per transaction. Each accepted transaction yields exactly one result
// transaction on the rsp_ channel: the flat address of the element in the tensor with
// the two selected axes exchanged, the element unchanged, tlast on the final element
// of the tensor, and tuser set when the shape or axis setting is unusable (then the
// address is zero, tlast is low and the walk does not advance).
// Each accepted transaction is registered in the output stage before rsp_tvalid. Throughput
// is one transaction per cycle unless the receiver stalls or the stride sequencer runs.
// The shape is programmed through csr_ while no transactions are in flight. Each write
// to a known register, and reset itself, restarts the walk at the tensor origin and
// runs the stride sequencer, which steps its two multipliers through the stride and step passes;
// req_tready stays low while it runs.
// When the receiver stalls, a two-entry output stage absorbs one more transaction
// before req_tready drops, and no result is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module tensor_transpose_index_remap
   import tti_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Input transactions. req_tdata: [31:0] elem_bits.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [ELEM_W-1:0]      req_tdata,
   // Result transactions. rsp_tdata: [23:0] dest_addr, [55:24] elem_out.
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tlast,
   // rsp_tuser: [0] fault.
   output logic                        rsp_tuser,
   // Configuration writes.
   input  wire logic                   csr_wen,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_state_type cfg;
   rsp_type       walk_rsp;
   rsp_type       out_rsp;
   logic          accept;
   logic          skid_ready;

   assign req_tready = !cfg.busy && skid_ready;
   assign accept     = req_tvalid && req_tready;

   tti_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tti_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .elem_bits (req_tdata),
      .rsp       (walk_rsp)
   );

   tti_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (skid_ready),
      .in_data   (walk_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_rsp)
   );

   // Pack the result fields onto the stream ports.
   assign rsp_tdata = RSP_TDATA_W'({out_rsp.elem_out, out_rsp.dest_addr});
   assign rsp_tlast = out_rsp.is_last;
   assign rsp_tuser = out_rsp.fault;

endmodule

`default_nettype wire

// ===== tb/sv/tb_tensor_transpose_index_remap.sv =====
// Testbench for the two-axis tensor transpose index remapper.
// Streams elements through shape and axis settings and checks every address and flag.
// Depends on tti_pkg and the tensor_transpose_index_remap RTL.
`timescale 1ns / 1ps

module tb_tensor_transpose_index_remap;
   import tti_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   wire logic              req_tready;
   logic [ELEM_W-1:0]      req_tdata = '0;
   wire logic              rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   wire logic [RSP_TDATA_W-1:0] rsp_tdata;
   wire logic              rsp_tlast;
   wire logic              rsp_tuser;
   logic                   csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   tensor_transpose_index_remap DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Shape registers as the testbench believes them, plus the walk state.
   logic [RANK_W-1:0]   shape_rank;
   logic [DIM_BITS-1:0] shape_size [MAX_DIMS];
   logic [AXIS_W-1:0]   swap_first_reg;
   logic [AXIS_W-1:0]   swap_second_reg;
   int unsigned         walk_digit [MAX_DIMS];
   longint unsigned     out_stride [MAX_DIMS];
   bit                  shape_fault;
   int                  axis_a;
   int                  axis_b;
   int                  used_dims;

   logic [ELEM_W-1:0] elem_backlog [$];
   rsp_type           remapped_elems [$];
   int                error_count = 0;
   int                idle_cycles = 0;
   bit                req_fired = 1'b0;

   // Product clamped just above the address range.
   function automatic longint unsigned clamp_product(input longint unsigned x,
                                                     input longint unsigned y);
      longint unsigned p;
      p = x * y;
      return (p > (64'd1 << ADDR_BITS)) ? (64'd1 << ADDR_BITS) + 1 : p;
   endfunction

   // Recompute fault, swapped axes and output strides; restart the walk.
   function automatic void rebuild_strides();
      longint unsigned swapped_dims [MAX_DIMS];
      longint unsigned total;
      longint unsigned t;
      int a;
      int b;
      int i;
      for (i = 0; i < MAX_DIMS; i++) begin
         walk_digit[i] = 0;
         out_stride[i] = 1;
         swapped_dims[i] = 1;
      end
      shape_fault = 1'b0;
      axis_a = 0;
      axis_b = 0;
      used_dims = 0;
      total = 1;
      if (shape_rank < 1 || shape_rank > MAX_DIMS) begin
         shape_fault = 1'b1;
         return;
      end
      used_dims = int'(shape_rank);
      a = int'($signed(swap_first_reg));
      b = int'($signed(swap_second_reg));
      if (a < 0) a += used_dims;
      if (b < 0) b += used_dims;
      if (a < 0 || a >= used_dims || b < 0 || b >= used_dims) begin
         shape_fault = 1'b1;
         return;
      end
      axis_a = a;
      axis_b = b;
      for (i = 0; i < used_dims; i++) begin
         if (shape_size[i] == 0) shape_fault = 1'b1;
         swapped_dims[i] = 64'(shape_size[i]);
         total = clamp_product(total, 64'(shape_size[i]));
      end
      if (total > (64'd1 << ADDR_BITS)) shape_fault = 1'b1;
      t = swapped_dims[axis_a];
      swapped_dims[axis_a] = swapped_dims[axis_b];
      swapped_dims[axis_b] = t;
      for (i = used_dims - 1; i > 0; i--) begin
         out_stride[i-1] = clamp_product(out_stride[i], swapped_dims[i]);
      end
   endfunction

   function automatic void reset_shape();
      int i;
      shape_rank = RANK_RESET;
      for (i = 0; i < MAX_DIMS; i++) shape_size[i] = SIZE_RESET;
      swap_first_reg = SWAP_FIRST_RESET;
      swap_second_reg = SWAP_SECOND_RESET;
      rebuild_strides();
   endfunction

   // Register write as the block sees it; unknown indexes change nothing.
   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_RANK: begin
            shape_rank = value[RANK_W-1:0];
         end
         CSR_SIZE_DIM0, CSR_SIZE_DIM1, CSR_SIZE_DIM2, CSR_SIZE_DIM3: begin
            shape_size[idx - CSR_SIZE_DIM0] = value[DIM_BITS-1:0];
         end
         CSR_SWAP_FIRST: begin
            swap_first_reg = value[AXIS_W-1:0];
         end
         CSR_SWAP_SECOND: begin
            swap_second_reg = value[AXIS_W-1:0];
         end
         default: begin
            return;
         end
      endcase
      rebuild_strides();
   endfunction

   // Expected result for one element; advances the odometer.
   function automatic rsp_type remap_element(input logic [ELEM_W-1:0] value);
      rsp_type r;
      longint unsigned addr;
      logic last;
      int pos;
      int i;
      int d;
      r.elem_out = value;
      r.fault = 1'b0;
      r.is_last = 1'b0;
      r.dest_addr = '0;
      if (shape_fault) begin
         r.fault = 1'b1;
         return r;
      end
      addr = 0;
      last = 1'b1;
      for (i = 0; i < used_dims; i++) begin
         pos = i;
         if (i == axis_a) pos = axis_b;
         else if (i == axis_b) pos = axis_a;
         addr += walk_digit[i] * out_stride[pos];
         if (walk_digit[i] + 1 != shape_size[i]) last = 1'b0;
      end
      // Innermost digit moves first.
      for (i = used_dims; i > 0; i--) begin
         d = i - 1;
         if (walk_digit[d] + 1 < shape_size[d]) begin
            walk_digit[d]++;
            break;
         end
         walk_digit[d] = 0;
      end
      r.dest_addr = addr[ADDR_BITS-1:0];
      r.is_last = last;
      return r;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         error_count++;
      end
   endtask

   // Input and result monitor: results are matched before new inputs are queued.
   always @(posedge clock) begin : monitor
      rsp_type want;
      bit rsp_fired;
      req_fired = req_tvalid && req_tready;
      rsp_fired = rsp_tvalid && rsp_tready;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_fired) begin
            if (remapped_elems.size() == 0) begin
               $error("result transaction with none expected, rsp_tdata %h", rsp_tdata);
               error_count++;
            end else begin
               want = remapped_elems.pop_front();
               check_field("dest_addr", want.dest_addr, rsp_tdata[ADDR_BITS-1:0]);
               check_field("elem_out", want.elem_out,
                           rsp_tdata[ADDR_BITS +: ELEM_W]);
               check_field("is_last", want.is_last, rsp_tlast);
               check_field("fault", want.fault, rsp_tuser);
            end
         end
         if (req_fired) remapped_elems.push_back(remap_element(req_tdata));
         idle_cycles = (req_fired || rsp_fired) ? 0 : idle_cycles + 1;
      end
   end

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin : drive_req
      logic nxt_valid;
      logic [ELEM_W-1:0] nxt_data;
      nxt_valid = req_tvalid;
      nxt_data = req_tdata;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!req_tvalid || req_fired) begin
         nxt_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (elem_backlog.size() > 0) begin
            nxt_data = elem_backlog.pop_front();
            nxt_valid = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 20);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: gap_left = 0;
                  9:          gap_left = $urandom_range(4, 15);
                  default:    gap_left = $urandom_range(1, 3);
               endcase
            end
         end
      end
      req_tvalid <= nxt_valid;
      req_tdata <= nxt_data;
   end

   // Receiver: stall pattern that changes mode at random intervals.
   int ready_mode = 0;
   int mode_left = 0;

   always @(negedge clock) begin : drive_rsp_ready
      logic rdy;
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(5, 60);
      end else begin
         mode_left--;
      end
      case (ready_mode)
         0:       rdy = 1'b1;
         1:       rdy = $urandom_range(0, 1);
         2:       rdy = ($urandom_range(0, 4) == 0);
         default: rdy = (mode_left % 8 == 0);
      endcase
      rsp_tready <= rdy;
   end

   // Ends the run when no transaction moves for too long.
   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      apply_reg(idx, value);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // Wait until every element is through and every result has come back.
   task automatic wait_drained();
      while (elem_backlog.size() != 0 || req_tvalid || remapped_elems.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random(input int count);
      repeat (count) elem_backlog.push_back($urandom());
   endtask

   initial begin : run_test
      int sent;
      int n;
      int eff_rank;
      int ax;
      int pick;
      int d;
      longint unsigned elems;
      logic [CSR_DATA_W-1:0] wr;

      reset_shape();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset shape is 1x1: every element is the last one at address zero.
      elem_backlog.push_back(32'h0000_0000);
      elem_backlog.push_back(32'hFFFF_FFFF);
      wait_drained();

      // Plain 2x3 transpose, one full tensor and one more element so the walk wraps.
      write_reg(CSR_SIZE_DIM0, 16'd2);
      write_reg(CSR_SIZE_DIM1, 16'd3);
      elem_backlog.push_back(32'hA5A5_5A5A);
      elem_backlog.push_back(32'h5A5A_A5A5);
      queue_random(5);
      wait_drained();

      // Same axis twice is the identity.
      write_reg(CSR_SWAP_SECOND, 16'd0);
      queue_random(3);
      wait_drained();

      // Rank three, axis given from the end.
      write_reg(CSR_RANK, 16'd3);
      write_reg(CSR_SIZE_DIM2, 16'd2);
      write_reg(CSR_SWAP_FIRST, 16'h0007);
      queue_random(3);
      wait_drained();

      // Bad ranks.
      write_reg(CSR_RANK, 16'd0);
      queue_random(1);
      wait_drained();
      write_reg(CSR_RANK, 16'd7);
      queue_random(1);
      wait_drained();

      // Rank four, most negative first axis against the highest second axis.
      write_reg(CSR_RANK, 16'd4);
      write_reg(CSR_SIZE_DIM3, 16'd2);
      write_reg(CSR_SWAP_FIRST, 16'h0004);
      write_reg(CSR_SWAP_SECOND, 16'd3);
      queue_random(3);
      wait_drained();

      // Axis out of range after normalization.
      write_reg(CSR_RANK, 16'd2);
      write_reg(CSR_SWAP_FIRST, 16'd0);
      write_reg(CSR_SWAP_SECOND, 16'h0005);
      queue_random(1);
      wait_drained();

      // Zero extent in a used dimension.
      write_reg(CSR_SWAP_SECOND, 16'd1);
      write_reg(CSR_SIZE_DIM0, 16'd0);
      queue_random(1);
      wait_drained();

      // Shape just over the address range, then exactly at it.
      write_reg(CSR_SIZE_DIM0, 16'd4097);
      write_reg(CSR_SIZE_DIM1, 16'd4096);
      queue_random(1);
      wait_drained();
      write_reg(CSR_SIZE_DIM0, 16'd4096);
      queue_random(1);
      wait_drained();

      // Largest extent.
      write_reg(CSR_SIZE_DIM0, 16'hFFFF);
      write_reg(CSR_SIZE_DIM1, 16'd256);
      queue_random(2);
      wait_drained();

      // Random shapes, mostly small and valid, some broken.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) == 0) write_reg(CSR_UNUSED, 16'($urandom()));
         if ($urandom_range(0, 9) < 7) begin
            wr = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : '0;
            if ($urandom_range(0, 9) == 0) wr[RANK_W-1:0] = 3'($urandom_range(5, 8));
            else wr[RANK_W-1:0] = 3'($urandom_range(1, 4));
            write_reg(CSR_RANK, wr);
         end
         for (d = 0; d < MAX_DIMS; d++) begin
            if ($urandom_range(0, 2) != 0) begin
               pick = $urandom_range(0, 39);
               if (pick == 0)      wr = 16'd0;
               else if (pick == 1) wr = 16'hFFFF;
               else if (pick == 2) wr = 16'($urandom_range(1, 65535));
               else if (pick < 6)  wr = 16'($urandom_range(6, 40));
               else                wr = 16'($urandom_range(1, 5));
               write_reg(CSR_IDX_W'(CSR_SIZE_DIM0 + d), wr);
            end
         end
         eff_rank = (shape_rank >= 1 && shape_rank <= MAX_DIMS) ? int'(shape_rank) : MAX_DIMS;
         for (d = 0; d < 2; d++) begin
            if ($urandom_range(0, 9) < 7) begin
               wr = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : '0;
               if ($urandom_range(0, 9) == 0) begin
                  wr[AXIS_W-1:0] = 3'($urandom_range(0, 7));
               end else begin
                  ax = $urandom_range(0, eff_rank - 1);
                  if ($urandom_range(0, 1) == 1) ax = ax - eff_rank;
                  wr[AXIS_W-1:0] = 3'(ax);
               end
               write_reg(d == 0 ? CSR_SWAP_FIRST : CSR_SWAP_SECOND, wr);
            end
         end
         elems = 1;
         for (d = 0; d < used_dims; d++) elems *= shape_size[d];
         if (shape_fault)     n = $urandom_range(1, 4);
         else if (elems > 60) n = $urandom_range(20, 60);
         else                 n = int'(elems) * $urandom_range(1, 2) + $urandom_range(0, 2);
         if (n > 60) n = 60;
         queue_random(n);
         sent += n;
         wait_drained();
      end

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
